// ===== hw/rtl/ipv4rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4rhc_pkg
// Shared types and constants of the IPv4 receive header checker: verdict
// codes, header limits and the record passed from the parser to the verdict.
// ----------------------------------------------------------------------------
package ipv4rhc_pkg;

    // Verdict codes, as they appear in the status field of a result word.
    localparam logic [3:0] STATUS_ICMP       = 4'd0;
    localparam logic [3:0] STATUS_UDP        = 4'd1;
    localparam logic [3:0] STATUS_TCP        = 4'd2;
    localparam logic [3:0] STATUS_OTHER      = 4'd3;
    localparam logic [3:0] STATUS_TOO_SHORT  = 4'd4;
    localparam logic [3:0] STATUS_BAD_VER    = 4'd5;
    localparam logic [3:0] STATUS_BAD_HLEN   = 4'd6;
    localparam logic [3:0] STATUS_BAD_TLEN   = 4'd7;
    localparam logic [3:0] STATUS_BAD_CSUM   = 4'd8;
    localparam logic [3:0] STATUS_NOT_LOCAL  = 4'd9;

    // Protocol numbers that get a class of their own.
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_TCP  = 8'd6;

    localparam logic [3:0]  IPV4_VERSION  = 4'd4;
    localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;

    // Header byte offsets of the captured fields.
    localparam logic [15:0] OFF_VER_IHL   = 16'd0;
    localparam logic [15:0] OFF_TLEN_HI   = 16'd2;
    localparam logic [15:0] OFF_TLEN_LO   = 16'd3;
    localparam logic [15:0] OFF_PROTO     = 16'd9;
    localparam logic [15:0] OFF_CSUM_HI   = 16'd10;
    localparam logic [15:0] OFF_CSUM_LO   = 16'd11;
    localparam logic [15:0] OFF_SRC_FIRST = 16'd12;
    localparam logic [15:0] OFF_SRC_LAST  = 16'd15;
    localparam logic [15:0] OFF_DST_FIRST = 16'd16;
    localparam logic [15:0] OFF_DST_LAST  = 16'd19;

    // Configuration register index.
    localparam logic REG_LOCAL_ADDR = 1'b0;

    localparam int RESULT_BITS = 104;

    // Everything the verdict needs about one finished packet.
    typedef struct packed {
        logic [15:0] len;
        logic [7:0]  ver_ihl;
        logic [20:0] sum;
        logic [15:0] csum;
        logic [15:0] tlen;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
    } pkt_rec_t;

endpackage

// ===== hw/rtl/ipv4rhc_front.sv =====
// ----------------------------------------------------------------------------
// ipv4rhc_front
// Byte parser: captures header fields and sums header words, and hands one
// record per packet to the queue when the last byte is taken.
// ----------------------------------------------------------------------------
module ipv4rhc_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic                   room,
    output logic                   byte_ready,
    output logic                   push,
    output ipv4rhc_pkg::pkt_rec_t  push_rec
);
    import ipv4rhc_pkg::*;

    logic [15:0] count_reg, count_next;
    logic [7:0]  ver_reg, ver_next;
    logic [7:0]  pend_reg, pend_next;
    logic [20:0] sum_reg, sum_next;
    logic [15:0] csum_reg, csum_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic [5:0]  hl;
    logic        in_hdr;
    logic        take;

    assign byte_ready = room;
    assign take       = byte_valid && room;

    always_comb
    begin
        ver_next   = (count_reg == OFF_VER_IHL) ? data_byte : ver_reg;
        hl         = {ver_next[3:0], 2'b00};
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        csum_next  = csum_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        pend_next  = pend_reg;
        sum_next   = sum_reg;

        // Offsets that hold no captured field leave every field unchanged.
        if (count_reg == OFF_TLEN_HI || count_reg == OFF_TLEN_LO)
        begin
            tlen_next = {tlen_reg[7:0], data_byte};
        end
        else if (count_reg == OFF_PROTO)
        begin
            proto_next = data_byte;
        end
        else if (count_reg == OFF_CSUM_HI || count_reg == OFF_CSUM_LO)
        begin
            csum_next = {csum_reg[7:0], data_byte};
        end
        else if (count_reg >= OFF_SRC_FIRST && count_reg <= OFF_SRC_LAST)
        begin
            src_next = {src_reg[23:0], data_byte};
        end
        else if (count_reg >= OFF_DST_FIRST && count_reg <= OFF_DST_LAST)
        begin
            dst_next = {dst_reg[23:0], data_byte};
        end

        // The checksum word itself is left out of the sum.
        in_hdr = count_reg < {10'd0, hl};
        if (in_hdr && !count_reg[0])
        begin
            pend_next = data_byte;
        end
        else if (in_hdr && count_reg != OFF_CSUM_LO)
        begin
            sum_next = sum_reg + {5'd0, pend_reg, data_byte};
        end

        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;
    end

    assign push             = take && last_byte;
    assign push_rec.len     = count_next;
    assign push_rec.ver_ihl = ver_next;
    assign push_rec.sum     = sum_next;
    assign push_rec.csum    = csum_next;
    assign push_rec.tlen    = tlen_next;
    assign push_rec.proto   = proto_next;
    assign push_rec.src     = src_next;
    assign push_rec.dst     = dst_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ver_reg   <= '0;
            pend_reg  <= '0;
            sum_reg   <= '0;
            csum_reg  <= '0;
            tlen_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (take && last_byte)
        begin
            // Packet finished: every per-packet field starts again from zero.
            count_reg <= '0;
            ver_reg   <= '0;
            pend_reg  <= '0;
            sum_reg   <= '0;
            csum_reg  <= '0;
            tlen_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (take)
        begin
            count_reg <= count_next;
            ver_reg   <= ver_next;
            pend_reg  <= pend_next;
            sum_reg   <= sum_next;
            csum_reg  <= csum_next;
            tlen_reg  <= tlen_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

endmodule

// ===== hw/rtl/ipv4rhc_queue.sv =====
// ----------------------------------------------------------------------------
// ipv4rhc_queue
// Two-entry queue of packet records between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module ipv4rhc_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ipv4rhc_pkg::pkt_rec_t  push_rec,
    input  logic                   pop,
    output logic                   room,
    output logic                   head_valid,
    output ipv4rhc_pkg::pkt_rec_t  head_rec
);
    import ipv4rhc_pkg::*;

    pkt_rec_t    slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        do_push, do_pop;

    assign room       = fill_reg != 2'd2;
    assign head_valid = fill_reg != 2'd0;
    assign head_rec   = slot_reg[rd_ptr_reg];

    assign do_push = push && room;
    assign do_pop  = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== hw/rtl/ipv4rhc_back.sv =====
// ----------------------------------------------------------------------------
// ipv4rhc_back
// Verdict stage: folds the header sum, runs the checks in order and holds
// the result word in an output register.
// ----------------------------------------------------------------------------
module ipv4rhc_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  ipv4rhc_pkg::pkt_rec_t               head_rec,
    input  logic [31:0]                         local_addr,
    input  logic                                out_ready,
    output logic                                pop,
    output logic                                out_valid,
    output logic [ipv4rhc_pkg::RESULT_BITS-1:0] out_data
);
    import ipv4rhc_pkg::*;

    logic        valid_reg, valid_next;
    logic [3:0]  status_reg, status_next;
    logic [7:0]  proto_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [5:0]  hbytes_reg, hbytes_next;
    logic [15:0] payload_reg, payload_next;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] calc_csum;
    logic [15:0] hl_wide;

    assign pop = head_valid && (!valid_reg || out_ready);

    always_comb
    begin
        fold1     = {1'b0, head_rec.sum[15:0]} + {12'd0, head_rec.sum[20:16]};
        fold2     = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        calc_csum = ~fold2[15:0];

        hbytes_next  = {head_rec.ver_ihl[3:0], 2'b00};
        hl_wide      = {10'd0, hbytes_next};
        payload_next = '0;

        priority if (head_rec.len < {10'd0, MIN_HDR_BYTES})
        begin
            status_next = STATUS_TOO_SHORT;
        end
        else if (head_rec.ver_ihl[7:4] != IPV4_VERSION)
        begin
            status_next = STATUS_BAD_VER;
        end
        else if (hbytes_next < MIN_HDR_BYTES || hl_wide > head_rec.len)
        begin
            status_next = STATUS_BAD_HLEN;
        end
        else if (head_rec.tlen > head_rec.len || head_rec.tlen < hl_wide)
        begin
            status_next = STATUS_BAD_TLEN;
        end
        else if (calc_csum != head_rec.csum)
        begin
            status_next = STATUS_BAD_CSUM;
        end
        else if (head_rec.dst != local_addr && head_rec.dst != BCAST_ADDR)
        begin
            status_next = STATUS_NOT_LOCAL;
        end
        else
        begin
            priority if (head_rec.proto == PROTO_ICMP)
                status_next = STATUS_ICMP;
            else if (head_rec.proto == PROTO_UDP)
                status_next = STATUS_UDP;
            else if (head_rec.proto == PROTO_TCP)
                status_next = STATUS_TCP;
            else
                status_next = STATUS_OTHER;
            payload_next = head_rec.tlen - hl_wide;
        end

        if (pop)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= status_next;
            proto_reg   <= head_rec.proto;
            src_reg     <= head_rec.src;
            dst_reg     <= head_rec.dst;
            hbytes_reg  <= hbytes_next;
            payload_reg <= payload_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {6'd0, payload_reg, hbytes_reg, dst_reg, src_reg, proto_reg,
                        status_reg};

endmodule

// ===== hw/rtl/ipv4_receive_header_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4_receive_header_checker
// Checks the header of each received IPv4 packet and gives one verdict word
// per packet, with the captured protocol, addresses and lengths.
// ----------------------------------------------------------------------------
// Packet bytes enter on the slave stream at one word per cycle while
// s_axis_tready is high, first header byte first, with tlast on the final
// byte; no payload is passed on. The parser updates the header fields and a
// running 21-bit sum of header words in the same cycle it takes a byte, so
// there is no gap between packets. When the last byte is taken a record of
// the packet enters a two-entry queue; the verdict stage folds the sum to
// 16-bit one's complement, checks (in order) length, version, header length,
// total length, checksum and destination, and then classifies the protocol.
// The queue and the output register let the input run on while a result
// waits, so s_axis_tready falls only once two verdicts are still pending
// behind a stalled output. The local address register is read and written
// through the APB port at byte address 0 and must only be changed while no
// packet is in flight.
// ----------------------------------------------------------------------------
module ipv4_receive_header_checker
(
    input  logic         clk,
    input  logic         rst_n,
    // Slave stream, one packet byte per word.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
    input  logic         s_axis_tlast,  // last_byte
    // Master stream, one verdict word per packet.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] status, [11:4] protocol, [43:12] source_addr, [75:44] dest_addr,
    // [81:76] header_bytes, [97:82] payload_length, [103:98] zero
    output logic [103:0] m_axis_tdata,
    // APB configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import ipv4rhc_pkg::*;

    logic [31:0] local_addr_reg, local_addr_next;
    logic        cfg_write;
    logic        room;
    logic        push;
    pkt_rec_t    push_rec;
    logic        pop;
    logic        head_valid;
    pkt_rec_t    head_rec;

    // Configuration register: the address bit above the word offset selects
    // the register, so a write to any other word is ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        local_addr_next = local_addr_reg;
        if (cfg_write && paddr[2] == REG_LOCAL_ADDR)
            local_addr_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_addr_reg <= '0;
        else
            local_addr_reg <= local_addr_next;
    end

    assign prdata = (paddr[2] == REG_LOCAL_ADDR) ? local_addr_reg : 32'd0;

    // Front: byte parser.
    ipv4rhc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .data_byte  (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .room       (room),
        .byte_ready (s_axis_tready),
        .push       (push),
        .push_rec   (push_rec)
    );

    // Queue of finished packet records.
    ipv4rhc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .room       (room),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // Back: verdict and output register.
    ipv4rhc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .local_addr (local_addr_reg),
        .out_ready  (m_axis_tready),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata)
    );

    // A verdict code is always one of the ten defined values.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= STATUS_NOT_LOCAL)
        else $error("verdict code out of range");

    // Only an accepted packet carries a payload length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[3:0] >= STATUS_TOO_SHORT)
            |-> m_axis_tdata[97:82] == 16'd0)
        else $error("payload length given for a rejected packet");

    // A record popped from the queue is in the output register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_axis_tvalid)
        else $error("popped record did not reach the output");

    // The parser never pushes a record while the queue is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("record pushed into a full queue");

endmodule
